@@ rtl/dbwu_pkg.sv @@
package dbwu_pkg;

    localparam int TableDepth = 64;
    localparam int IdxBits = (TableDepth > 1) ? $clog2(TableDepth) : 1;
    localparam int CntBits = $clog2(TableDepth + 1);
    localparam int AddrBits = 32;
    localparam logic [7:0] SigTrap = 8'd5;

    localparam logic [3:0] CmdPc = 4'd0;
    localparam logic [3:0] CmdRead = 4'd1;
    localparam logic [3:0] CmdWrite = 4'd2;
    localparam logic [3:0] CmdSignal = 4'd3;
    localparam logic [3:0] CmdAddBp = 4'd4;
    localparam logic [3:0] CmdRemBp = 4'd5;
    localparam logic [3:0] CmdAddWp = 4'd6;
    localparam logic [3:0] CmdRemWp = 4'd7;
    localparam logic [3:0] CmdHalt = 4'd8;
    localparam logic [3:0] CmdQuery = 4'd9;
    localparam logic [3:0] CmdCont = 4'd10;
    localparam logic [3:0] CmdStep = 4'd11;
    localparam logic [3:0] CmdClear = 4'd12;

    localparam logic [1:0] KindWrite = 2'd0;
    localparam logic [1:0] KindRead = 2'd1;
    localparam logic [1:0] KindAccess = 2'd2;
    localparam logic [1:0] KindBad = 2'd3;

    localparam logic [1:0] EvNone = 2'd0;
    localparam logic [1:0] EvStop = 2'd1;
    localparam logic [1:0] EvWatch = 2'd2;

    typedef struct packed {
        logic [3:0] cmd;
        logic [31:0] addr;
        logic [31:0] aend;
        logic [31:0] wend;
        logic [1:0] kind;
        logic [7:0] sig;
    } t_item;

    localparam int ItemBits = $bits(t_item);

endpackage

@@ rtl/dbwu_ram.sv @@
module dbwu_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/dbwu_front.sv @@
module dbwu_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [3:0]            i_command,
    input  logic [31:0]           i_address,
    input  logic [3:0]            i_access_size,
    input  logic [31:0]           i_watch_length,
    input  logic [1:0]            i_watch_kind,
    input  logic [7:0]            i_signal_code,
    input  logic                  i_take,
    output logic                  o_busy,
    output logic                  o_vld,
    output dbwu_pkg::t_item       o_item
);
    // two-entry queue between classify and execute
    dbwu_pkg::t_item r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    dbwu_pkg::t_item n_item;
    logic push;

    always_comb begin
        n_item.cmd = i_command;
        n_item.addr = i_address;
        n_item.aend = i_address + {28'd0, i_access_size} - 32'd1;
        n_item.wend = i_address + i_watch_length - 32'd1;
        n_item.kind = i_watch_kind;
        n_item.sig = i_signal_code;
    end

    assign o_busy = (r_cnt == 2'd2);
    assign push = i_start && !o_busy;
    assign o_vld = (r_cnt != 2'd0);
    assign o_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_take};
        end
    end
endmodule

@@ rtl/dbwu_back.sv @@
module dbwu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_debug_enable,
    input  logic                  i_vld,
    input  dbwu_pkg::t_item       i_item,
    output logic                  o_take,
    output logic                  o_strobe,
    output logic                  o_proceed,
    output logic [1:0]            o_stop_event,
    output logic [7:0]            o_stop_signal,
    output logic [1:0]            o_hit_kind,
    output logic [31:0]           o_hit_address,
    output logic                  o_table_full,
    output logic                  o_halted
);
    localparam int IB = dbwu_pkg::IdxBits;
    localparam int CB = dbwu_pkg::CntBits;
    localparam int WpW = 66;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;
    t_state r_state;

    dbwu_pkg::t_item r_it;
    logic [dbwu_pkg::TableDepth-1:0] r_bpv, r_wpv;
    logic r_halt, r_sent, r_step, r_hs;
    logic [CB-1:0] r_ptr;
    logic r_found;
    logic [IB-1:0] r_slot;
    logic [1:0] r_hkind;

    logic [IB-1:0] raddr, waddr;
    logic bp_we, wp_we;
    logic [31:0] bp_rd;
    logic [WpW-1:0] wp_rd, wp_wd;
    logic [IB-1:0] cur;
    logic cur_ok;

    logic r_o_stb, r_o_pro, r_o_full;
    logic [1:0] r_o_ev, r_o_hk;
    logic [7:0] r_o_sig;
    logic [31:0] r_o_ha;

    // slot whose read data is on the ram outputs this cycle
    assign cur = r_ptr[IB-1:0] - IB'(1);
    assign cur_ok = (r_ptr != '0);
    assign raddr = r_ptr[IB-1:0];

    dbwu_ram #(.Width(32), .Depth(dbwu_pkg::TableDepth)) u_bp (
        .i_clk(i_clk), .i_we(bp_we), .i_waddr(waddr), .i_wdata(r_it.addr),
        .i_raddr(raddr), .o_rdata(bp_rd)
    );
    dbwu_ram #(.Width(WpW), .Depth(dbwu_pkg::TableDepth)) u_wp (
        .i_clk(i_clk), .i_we(wp_we), .i_waddr(waddr), .i_wdata(wp_wd),
        .i_raddr(raddr), .o_rdata(wp_rd)
    );

    logic [31:0] wp_s, wp_e;
    logic [1:0] wp_k;
    assign wp_s = wp_rd[65:34];
    assign wp_e = wp_rd[33:2];
    assign wp_k = wp_rd[1:0];
    assign wp_wd = {r_it.addr, r_it.wend, r_it.kind};

    logic is_scan_cmd, bp_match, wp_match, rm_match, last;
    logic [IB-1:0] free_bp, free_wp;
    logic bp_free, wp_free;
    logic [1:0] other;

    assign other = (r_it.cmd == dbwu_pkg::CmdRead) ? dbwu_pkg::KindRead : dbwu_pkg::KindWrite;
    assign bp_match = cur_ok && r_bpv[cur] && (bp_rd == r_it.addr);
    assign wp_match = cur_ok && r_wpv[cur]
        && (wp_k == other || wp_k == dbwu_pkg::KindAccess)
        && (wp_s <= r_it.aend) && (r_it.addr <= wp_e);
    assign rm_match = cur_ok && r_wpv[cur] && wp_s == r_it.addr
        && wp_e == r_it.wend && wp_k == r_it.kind;
    assign last = (r_ptr == CB'(dbwu_pkg::TableDepth));

    always_comb begin
        free_bp = '0;
        bp_free = 1'b0;
        free_wp = '0;
        wp_free = 1'b0;
        for (int i = dbwu_pkg::TableDepth - 1; i >= 0; i--) begin
            if (!r_bpv[i]) begin
                free_bp = IB'(i);
                bp_free = 1'b1;
            end
            if (!r_wpv[i]) begin
                free_wp = IB'(i);
                wp_free = 1'b1;
            end
        end
    end

    always_comb begin
        is_scan_cmd = 1'b0;
        unique case (i_item.cmd)
            dbwu_pkg::CmdPc: is_scan_cmd = i_debug_enable;
            dbwu_pkg::CmdRead, dbwu_pkg::CmdWrite,
            dbwu_pkg::CmdRemBp: is_scan_cmd = 1'b1;
            dbwu_pkg::CmdRemWp: is_scan_cmd = (i_item.kind != dbwu_pkg::KindBad);
            default: is_scan_cmd = 1'b0;
        endcase
    end

    assign o_take = (r_state == S_IDLE) && i_vld;
    assign bp_we = (r_state == S_DONE) && r_it.cmd == dbwu_pkg::CmdAddBp && bp_free;
    assign wp_we = (r_state == S_DONE) && r_it.cmd == dbwu_pkg::CmdAddWp
        && r_it.kind != dbwu_pkg::KindBad && wp_free;
    assign waddr = (r_it.cmd == dbwu_pkg::CmdAddBp) ? free_bp : free_wp;

    logic need;
    assign need = r_halt || r_found;

    logic n_halt, n_sent, n_step, n_hs, n_pro, n_full;
    logic [1:0] n_ev, n_hk;
    logic [7:0] n_sig;
    logic [31:0] n_ha;

    always_comb begin
        n_halt = r_halt;
        n_sent = r_sent;
        n_step = r_step;
        n_hs = r_hs;
        n_pro = 1'b0;
        n_ev = dbwu_pkg::EvNone;
        n_sig = '0;
        n_hk = '0;
        n_ha = '0;
        n_full = 1'b0;
        case (r_it.cmd)
            dbwu_pkg::CmdPc: begin
                if (!i_debug_enable) begin
                    n_pro = 1'b1;
                end else begin
                    if (need) begin
                        n_halt = 1'b1;
                        if (!r_sent) begin
                            n_sent = 1'b1;
                            n_ev = dbwu_pkg::EvStop;
                            n_sig = dbwu_pkg::SigTrap;
                        end
                    end
                    if (r_step) begin
                        n_step = 1'b0;
                        n_halt = 1'b1;
                    end
                    n_pro = !need;
                end
            end
            dbwu_pkg::CmdRead, dbwu_pkg::CmdWrite: begin
                if (r_found) begin
                    n_halt = 1'b1;
                    n_sent = 1'b1;
                    n_ev = dbwu_pkg::EvWatch;
                    n_sig = dbwu_pkg::SigTrap;
                    n_hk = r_hkind;
                    n_ha = r_it.addr;
                end
            end
            dbwu_pkg::CmdSignal: begin
                if (!i_debug_enable || !r_hs) begin
                    n_pro = 1'b1;
                end else if (!r_halt) begin
                    n_halt = 1'b1;
                    n_sent = 1'b1;
                    n_ev = dbwu_pkg::EvStop;
                    n_sig = r_it.sig;
                    n_pro = 1'b1;
                end
            end
            dbwu_pkg::CmdAddBp: n_full = !bp_free;
            dbwu_pkg::CmdAddWp: n_full = (r_it.kind != dbwu_pkg::KindBad) && !wp_free;
            dbwu_pkg::CmdHalt: begin
                n_halt = 1'b1;
                n_sent = 1'b0;
            end
            dbwu_pkg::CmdQuery: begin
                n_halt = 1'b1;
                n_sent = 1'b1;
                n_ev = dbwu_pkg::EvStop;
                n_sig = dbwu_pkg::SigTrap;
            end
            dbwu_pkg::CmdCont: begin
                n_hs = 1'b1;
                n_halt = 1'b0;
                n_sent = 1'b0;
            end
            dbwu_pkg::CmdStep: begin
                n_step = 1'b1;
                n_halt = 1'b0;
                n_sent = 1'b0;
            end
            dbwu_pkg::CmdClear: begin
                n_halt = 1'b0;
                n_sent = 1'b0;
                n_step = 1'b0;
                n_hs = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bpv <= '0;
            r_wpv <= '0;
            r_halt <= 1'b0;
            r_sent <= 1'b0;
            r_step <= 1'b0;
            r_hs <= 1'b0;
            r_ptr <= '0;
            r_found <= 1'b0;
            r_o_stb <= 1'b0;
        end else begin
            r_o_stb <= (r_state == S_DONE);
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_it <= i_item;
                        r_ptr <= '0;
                        r_found <= 1'b0;
                        r_state <= is_scan_cmd ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    r_ptr <= r_ptr + CB'(1);
                    case (r_it.cmd)
                        dbwu_pkg::CmdPc: if (bp_match) r_found <= 1'b1;
                        dbwu_pkg::CmdRead, dbwu_pkg::CmdWrite: begin
                            if (wp_match && !r_found) begin
                                r_found <= 1'b1;
                                r_hkind <= wp_k;
                            end
                        end
                        dbwu_pkg::CmdRemBp: if (bp_match) r_bpv[cur] <= 1'b0;
                        default: if (rm_match) r_wpv[cur] <= 1'b0;
                    endcase
                    if (last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    r_o_pro <= n_pro;
                    r_o_ev <= n_ev;
                    r_o_sig <= n_sig;
                    r_o_hk <= n_hk;
                    r_o_ha <= n_ha;
                    r_o_full <= n_full;
                    r_halt <= n_halt;
                    r_sent <= n_sent;
                    r_step <= n_step;
                    r_hs <= n_hs;
                    if (r_it.cmd == dbwu_pkg::CmdClear) begin
                        r_bpv <= '0;
                        r_wpv <= '0;
                    end
                    if (bp_we) r_bpv[free_bp] <= 1'b1;
                    if (wp_we) r_wpv[free_wp] <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_o_stb;
    assign o_proceed = r_o_pro;
    assign o_stop_event = r_o_ev;
    assign o_stop_signal = r_o_sig;
    assign o_hit_kind = r_o_hk;
    assign o_hit_address = r_o_ha;
    assign o_table_full = r_o_full;
    assign o_halted = r_halt;
endmodule

@@ rtl/debug_breakpoint_watchpoint_unit.sv @@
// Debug trigger unit. A command is taken when start is high and busy is
// low; a two-entry command queue lets the host issue while the execute side
// works. PC (with debug enabled), memory-report and remove commands (not a
// watchpoint removal of the bad kind) scan the 64-slot breakpoint or
// watchpoint memory one slot per cycle; every other command skips the scan.
// Each result shows for one cycle with o_valid high and cannot be held off.
// o_halted follows the halt flag and is valid together with o_valid.
module debug_breakpoint_watchpoint_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_command,
    input  logic [31:0] i_address,
    input  logic [3:0]  i_access_size,
    input  logic [31:0] i_watch_length,
    input  logic [1:0]  i_watch_kind,
    input  logic [7:0]  i_signal_code,
    output logic        o_valid,
    output logic        o_proceed,
    output logic [1:0]  o_stop_event,
    output logic [7:0]  o_stop_signal,
    output logic [1:0]  o_hit_kind,
    output logic [31:0] o_hit_address,
    output logic        o_table_full,
    output logic        o_halted
);
    logic r_debug_enable;
    logic vld, take;
    dbwu_pkg::t_item item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debug_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_debug_enable <= i_cfg_wdata;
        end
    end

    dbwu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_command(i_command), .i_address(i_address),
        .i_access_size(i_access_size), .i_watch_length(i_watch_length),
        .i_watch_kind(i_watch_kind), .i_signal_code(i_signal_code),
        .i_take(take), .o_busy(busy), .o_vld(vld), .o_item(item)
    );

    dbwu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_debug_enable(r_debug_enable),
        .i_vld(vld), .i_item(item), .o_take(take), .o_strobe(o_valid),
        .o_proceed(o_proceed), .o_stop_event(o_stop_event),
        .o_stop_signal(o_stop_signal), .o_hit_kind(o_hit_kind),
        .o_hit_address(o_hit_address), .o_table_full(o_table_full),
        .o_halted(o_halted)
    );
endmodule

@@ rtl/dbwu_checker.sv @@
module dbwu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic [1:0]  o_stop_event,
    input logic [7:0]  o_stop_signal,
    input logic        o_proceed,
    input logic [1:0]  o_hit_kind,
    input logic [31:0] o_hit_address
);
    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stop_event <= dbwu_pkg::EvWatch) else $error("bad stop event");
    a_watch_trap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stop_event == dbwu_pkg::EvWatch |-> o_stop_signal == dbwu_pkg::SigTrap
        && !o_proceed) else $error("watch reply without trap");
    a_no_ev_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stop_event == dbwu_pkg::EvNone |-> o_stop_signal == 8'd0)
        else $error("signal without reply");
    a_hit_only_watch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stop_event != dbwu_pkg::EvWatch |-> o_hit_kind == 2'd0
        && o_hit_address == 32'd0) else $error("hit data without watch");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("results back to back");
endmodule

bind debug_breakpoint_watchpoint_unit dbwu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .o_stop_event(o_stop_event), .o_stop_signal(o_stop_signal),
    .o_proceed(o_proceed), .o_hit_kind(o_hit_kind), .o_hit_address(o_hit_address)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] addr;
        logic [3:0]  size;
        logic [31:0] len;
        logic [1:0]  kind;
        logic [7:0]  sig;
    } t_cmd;

    typedef struct {
        logic        proceed;
        logic [1:0]  ev;
        logic [7:0]  ssig;
        logic [1:0]  hkind;
        logic [31:0] haddr;
        logic        full;
        logic        halted;
    } t_reply;

    class t_trigger_scoreboard;
        logic [31:0] bp_addr [dbwu_pkg::TableDepth];
        logic        bp_used [dbwu_pkg::TableDepth];
        logic [31:0] wp_lo [dbwu_pkg::TableDepth];
        logic [31:0] wp_hi [dbwu_pkg::TableDepth];
        logic [1:0]  wp_knd [dbwu_pkg::TableDepth];
        logic        wp_used [dbwu_pkg::TableDepth];
        logic        halt_f, sent_f, step_f, shake_f, dbg_en;
        t_reply      pending_replies[$];
        int          mismatches;

        function new();
            mismatches = 0;
            dbg_en = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < dbwu_pkg::TableDepth; i++) begin
                bp_used[i] = 0;
                wp_used[i] = 0;
            end
            halt_f = 0;
            sent_f = 0;
            step_f = 0;
            shake_f = 0;
        endfunction

        function void note_command(t_cmd c);
            t_reply r;
            logic need;
            logic [31:0] aend, wend;
            int slot;
            r = '{default: 0};
            aend = c.addr + {28'd0, c.size} - 32'd1;
            wend = c.addr + c.len - 32'd1;
            slot = -1;
            case (c.cmd)
                dbwu_pkg::CmdPc: begin
                    if (!dbg_en) begin
                        r.proceed = 1;
                    end else begin
                        need = halt_f;
                        for (int i = 0; i < dbwu_pkg::TableDepth; i++)
                            if (bp_used[i] && bp_addr[i] == c.addr) need = 1;
                        if (need) begin
                            halt_f = 1;
                            if (!sent_f) begin
                                sent_f = 1;
                                r.ev = dbwu_pkg::EvStop;
                                r.ssig = dbwu_pkg::SigTrap;
                            end
                        end
                        if (step_f) begin
                            step_f = 0;
                            halt_f = 1;
                        end
                        r.proceed = !need;
                    end
                end
                dbwu_pkg::CmdRead, dbwu_pkg::CmdWrite: begin
                    for (int i = 0; i < dbwu_pkg::TableDepth; i++)
                        if (slot < 0 && wp_used[i] &&
                            (wp_knd[i] == dbwu_pkg::KindAccess ||
                             wp_knd[i] == ((c.cmd == dbwu_pkg::CmdRead) ?
                                           dbwu_pkg::KindRead : dbwu_pkg::KindWrite)) &&
                            wp_lo[i] <= aend && c.addr <= wp_hi[i])
                            slot = i;
                    if (slot >= 0) begin
                        halt_f = 1;
                        sent_f = 1;
                        r.ev = dbwu_pkg::EvWatch;
                        r.ssig = dbwu_pkg::SigTrap;
                        r.hkind = wp_knd[slot];
                        r.haddr = c.addr;
                    end
                end
                dbwu_pkg::CmdSignal: begin
                    if (!dbg_en || !shake_f) begin
                        r.proceed = 1;
                    end else if (!halt_f) begin
                        halt_f = 1;
                        sent_f = 1;
                        r.ev = dbwu_pkg::EvStop;
                        r.ssig = c.sig;
                        r.proceed = 1;
                    end
                end
                dbwu_pkg::CmdAddBp: begin
                    for (int i = 0; i < dbwu_pkg::TableDepth; i++)
                        if (slot < 0 && !bp_used[i]) slot = i;
                    if (slot >= 0) begin
                        bp_used[slot] = 1;
                        bp_addr[slot] = c.addr;
                    end else begin
                        r.full = 1;
                    end
                end
                dbwu_pkg::CmdRemBp: begin
                    for (int i = 0; i < dbwu_pkg::TableDepth; i++)
                        if (bp_used[i] && bp_addr[i] == c.addr) bp_used[i] = 0;
                end
                dbwu_pkg::CmdAddWp: begin
                    if (c.kind != dbwu_pkg::KindBad) begin
                        for (int i = 0; i < dbwu_pkg::TableDepth; i++)
                            if (slot < 0 && !wp_used[i]) slot = i;
                        if (slot >= 0) begin
                            wp_used[slot] = 1;
                            wp_lo[slot] = c.addr;
                            wp_hi[slot] = wend;
                            wp_knd[slot] = c.kind;
                        end else begin
                            r.full = 1;
                        end
                    end
                end
                dbwu_pkg::CmdRemWp: begin
                    if (c.kind != dbwu_pkg::KindBad)
                        for (int i = 0; i < dbwu_pkg::TableDepth; i++)
                            if (wp_used[i] && wp_lo[i] == c.addr && wp_hi[i] == wend &&
                                wp_knd[i] == c.kind)
                                wp_used[i] = 0;
                end
                dbwu_pkg::CmdHalt: begin
                    halt_f = 1;
                    sent_f = 0;
                end
                dbwu_pkg::CmdQuery: begin
                    halt_f = 1;
                    sent_f = 1;
                    r.ev = dbwu_pkg::EvStop;
                    r.ssig = dbwu_pkg::SigTrap;
                end
                dbwu_pkg::CmdCont: begin
                    shake_f = 1;
                    halt_f = 0;
                    sent_f = 0;
                end
                dbwu_pkg::CmdStep: begin
                    step_f = 1;
                    halt_f = 0;
                    sent_f = 0;
                end
                dbwu_pkg::CmdClear: wipe();
                default: ;
            endcase
            r.halted = halt_f;
            pending_replies = {pending_replies, r};
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_reply(t_reply got);
            t_reply want;
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected reply", 32'd1, 32'd0);
            end else begin
                want = pending_replies.pop_front();
                if (got.proceed !== want.proceed)
                    report_mismatch("proceed", got.proceed, want.proceed);
                if (got.ev !== want.ev) report_mismatch("stop_event", got.ev, want.ev);
                if (got.ssig !== want.ssig) report_mismatch("stop_signal", got.ssig, want.ssig);
                if (got.hkind !== want.hkind) report_mismatch("hit_kind", got.hkind, want.hkind);
                if (got.haddr !== want.haddr)
                    report_mismatch("hit_address", got.haddr, want.haddr);
                if (got.full !== want.full) report_mismatch("table_full", got.full, want.full);
                if (got.halted !== want.halted)
                    report_mismatch("halted", got.halted, want.halted);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        start;
    logic        busy;
    logic [3:0]  i_command;
    logic [31:0] i_address;
    logic [3:0]  i_access_size;
    logic [31:0] i_watch_length;
    logic [1:0]  i_watch_kind;
    logic [7:0]  i_signal_code;
    logic        o_valid;
    logic        o_proceed;
    logic [1:0]  o_stop_event;
    logic [7:0]  o_stop_signal;
    logic [1:0]  o_hit_kind;
    logic [31:0] o_hit_address;
    logic        o_table_full;
    logic        o_halted;

    t_trigger_scoreboard sb;
    logic [31:0] addr_pool [8];
    logic [31:0] len_pool [4];
    bit          gaps_on;

    debug_breakpoint_watchpoint_unit u_dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        t_reply r;
        if (i_rst_n && o_valid) begin
            r.proceed = o_proceed;
            r.ev = o_stop_event;
            r.ssig = o_stop_signal;
            r.hkind = o_hit_kind;
            r.haddr = o_hit_address;
            r.full = o_table_full;
            r.halted = o_halted;
            sb.check_reply(r);
        end
    end

    task send_command(t_cmd c);
        @(negedge i_clk);
        i_command <= c.cmd;
        i_address <= c.addr;
        i_access_size <= c.size;
        i_watch_length <= c.len;
        i_watch_kind <= c.kind;
        i_signal_code <= c.sig;
        start <= 1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_command(c);
    endtask

    task idle_gap();
        int n;
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
            @(negedge i_clk);
            start <= 0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task drain();
        @(negedge i_clk);
        start <= 0;
        while (sb.pending_replies.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task write_enable(logic v);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.dbg_en = v;
    endtask

    function automatic t_cmd make_cmd(logic [3:0] cmd, logic [31:0] addr, logic [3:0] size,
                                      logic [31:0] len, logic [1:0] kind, logic [7:0] sig);
        t_cmd c;
        c.cmd = cmd;
        c.addr = addr;
        c.size = size;
        c.len = len;
        c.kind = kind;
        c.sig = sig;
        return c;
    endfunction

    function automatic t_cmd random_cmd(bit fill);
        t_cmd c;
        int w;
        c.addr = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 7)] : $urandom;
        c.size = 4'($urandom_range(1, 8));
        c.len = ($urandom_range(0, 4) != 0) ? len_pool[$urandom_range(0, 3)] : $urandom;
        c.kind = ($urandom_range(0, 30) == 0) ? dbwu_pkg::KindBad : 2'($urandom_range(0, 2));
        c.sig = 8'($urandom);
        w = $urandom_range(0, 99);
        if (fill) begin
            c.cmd = (w < 45) ? dbwu_pkg::CmdAddBp :
                    (w < 90) ? dbwu_pkg::CmdAddWp : 4'($urandom_range(0, 2));
        end else if (w < 20) c.cmd = dbwu_pkg::CmdPc;
        else if (w < 30) c.cmd = dbwu_pkg::CmdRead;
        else if (w < 40) c.cmd = dbwu_pkg::CmdWrite;
        else if (w < 48) c.cmd = dbwu_pkg::CmdSignal;
        else if (w < 58) c.cmd = dbwu_pkg::CmdAddBp;
        else if (w < 63) c.cmd = dbwu_pkg::CmdRemBp;
        else if (w < 73) c.cmd = dbwu_pkg::CmdAddWp;
        else if (w < 78) c.cmd = dbwu_pkg::CmdRemWp;
        else if (w < 83) c.cmd = dbwu_pkg::CmdHalt;
        else if (w < 88) c.cmd = dbwu_pkg::CmdQuery;
        else if (w < 93) c.cmd = dbwu_pkg::CmdCont;
        else if (w < 98) c.cmd = dbwu_pkg::CmdStep;
        else c.cmd = dbwu_pkg::CmdClear;
        return c;
    endfunction

    initial begin
        sb = new();
        addr_pool = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h1000, 32'h1004,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h1002};
        len_pool = '{32'd0, 32'd1, 32'd4, 32'd16};
        gaps_on = 1;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        start = 0;
        i_command = dbwu_pkg::CmdPc;
        i_address = 0;
        i_access_size = 4'd1;
        i_watch_length = 0;
        i_watch_kind = dbwu_pkg::KindWrite;
        i_signal_code = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: disabled reports, then enabled special cases
        send_command(make_cmd(dbwu_pkg::CmdPc, 32'h1000, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdSignal, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'hFF));
        write_enable(1);
        send_command(make_cmd(dbwu_pkg::CmdAddBp, 32'hFFFF_FFFF, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdAddBp, 32'hFFFF_FFFF, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdPc, 32'hFFFF_FFFF, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdPc, 32'hFFFF_FFFF, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdSignal, 32'h0, 4'd8, 32'd0,
                              dbwu_pkg::KindWrite, 8'd11));
        send_command(make_cmd(dbwu_pkg::CmdCont, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdSignal, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'hA5));
        send_command(make_cmd(dbwu_pkg::CmdSignal, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'h5A));
        send_command(make_cmd(dbwu_pkg::CmdStep, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdPc, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdRemBp, 32'hFFFF_FFFF, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdAddWp, 32'hFFFF_FFFC, 4'd1, 32'd8,
                              dbwu_pkg::KindRead, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdAddWp, 32'h1000, 4'd1, 32'd0,
                              dbwu_pkg::KindAccess, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdAddWp, 32'h1000, 4'd1, 32'd4,
                              dbwu_pkg::KindBad, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdWrite, 32'hFFFF_FFFE, 4'd8, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdRead, 32'hFFFF_FFFE, 4'd8, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdWrite, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdRemWp, 32'h1000, 4'd1, 32'd0,
                              dbwu_pkg::KindBad, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdRemWp, 32'hFFFF_FFFC, 4'd1, 32'd8,
                              dbwu_pkg::KindRead, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdHalt, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdQuery, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        send_command(make_cmd(dbwu_pkg::CmdClear, 32'h0, 4'd1, 32'd0,
                              dbwu_pkg::KindWrite, 8'd0));
        // unknown command
        send_command(make_cmd(4'd13, 32'h0, 4'd1, 32'd0, dbwu_pkg::KindWrite, 8'd0));

        for (int phase = 0; phase < 6; phase++) begin
            write_enable((phase % 3) != 2);
            gaps_on = (phase != 1);
            for (int n = 0; n < 250; n++) begin
                send_command(random_cmd((phase == 3 && n < 140) || (phase == 5 && n < 70)));
                idle_gap();
            end
        end

        drain();
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
